[rtl/pdc_pkg.sv]
// Shared types, codes and reset constants of the dual-wheel PID duty controller.
`default_nettype none

package pdc_pkg;

  localparam int DUTY_W      = 16;
  localparam int ERR_W       = 16;
  localparam int COUNT_W     = 16;
  localparam int TARGET_W    = 8;
  localparam int GAIN_W      = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int ACC_WIDTH_DEF = 16;

  typedef logic [1:0]             func_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  // Item function codes.
  localparam func_t FUNC_PULSE = 2'd0;
  localparam func_t FUNC_TICK  = 2'd1;
  localparam func_t FUNC_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam cfg_index_t CFG_TARGET_COUNT = 3'd0;
  localparam cfg_index_t CFG_GAIN_P       = 3'd1;
  localparam cfg_index_t CFG_GAIN_I       = 3'd2;
  localparam cfg_index_t CFG_GAIN_D       = 3'd3;
  localparam cfg_index_t CFG_DUTY_LIMIT   = 3'd4;
  localparam cfg_index_t CFG_START_DUTY   = 3'd5;

  // Reset values.
  localparam logic [TARGET_W-1:0] RST_TARGET_COUNT = 8'd20;
  localparam logic [GAIN_W-1:0]   RST_GAIN_P       = 16'd768;
  localparam logic [GAIN_W-1:0]   RST_GAIN_I       = 16'd128;
  localparam logic [GAIN_W-1:0]   RST_GAIN_D       = 16'd179;
  localparam logic [DUTY_W-1:0]   RST_DUTY_LIMIT   = 16'd10000;
  localparam logic [DUTY_W-1:0]   RST_START_DUTY   = 16'd9000;

endpackage

`default_nettype wire

[rtl/pdc_if.sv]
// Item channel interfaces: encoder/tick/clear items in, duty and error results out.
`default_nettype none

interface pdc_in_if;
  import pdc_pkg::*;

  logic  valid;
  logic  ready;
  func_t func;
  logic  left_pulse;
  logic  right_pulse;

  modport source (output valid, output func, output left_pulse, output right_pulse,
                  input ready);
  modport sink   (input valid, input func, input left_pulse, input right_pulse,
                  output ready);
endinterface

interface pdc_out_if;
  import pdc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [DUTY_W-1:0]        left_duty;
  logic [DUTY_W-1:0]        right_duty;
  logic signed [ERR_W-1:0]  left_error;
  logic signed [ERR_W-1:0]  right_error;

  modport source (output valid, output left_duty, output right_duty, output left_error,
                  output right_error, input ready);
  modport sink   (input valid, input left_duty, input right_duty, input left_error,
                  input right_error, output ready);
endinterface

`default_nettype wire

[rtl/dual_wheel_pid_duty_control_unit.sv]
// Top level: two-wheel pulse counters and PID duty update, one item per cycle.
// An accepted item waits in the input register; its result is registered in the result
// register, and a stalled result side holds both registers.
// Throughput: one item per cycle; the input register advances whenever the result
// register is empty or being taken, and all wheel state updates in that same cycle.
// Reset (synchronous, rst_n low): config returns to its defaults, counts, errors and
// sums clear, both duties load 9000, and both item registers empty.
`default_nettype none

module dual_wheel_pid_duty_control_unit #(
  parameter int ACC_WIDTH = pdc_pkg::ACC_WIDTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  pdc_in_if.sink                in_item,
  pdc_out_if.source             out_item,
  input  wire                   cfg_we,
  input  pdc_pkg::cfg_index_t   cfg_index,
  input  pdc_pkg::cfg_data_t    cfg_data
);
  import pdc_pkg::*;

  localparam int NW = 2;  // wheel 0 is left, wheel 1 is right

  // Product widths: gain_p*e is 17x16, gain_d*d is 17x17, gain_i*sum is 17xACC.
  localparam int PP_W = GAIN_W + 1 + ERR_W;
  localparam int PD_W = GAIN_W + 1 + ERR_W + 1;
  localparam int PI_W = GAIN_W + 1 + ACC_WIDTH;
  localparam int MX_W = (PI_W > PD_W) ? PI_W : PD_W;
  localparam int TW   = MX_W + 3;
  // Width of the sum update before saturation.
  localparam int SW   = ((ACC_WIDTH > ERR_W) ? ACC_WIDTH : ERR_W) + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [TARGET_W-1:0] target_r;
  logic [GAIN_W-1:0]   gain_p_r, gain_i_r, gain_d_r;
  logic [DUTY_W-1:0]   duty_limit_r, start_duty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= RST_TARGET_COUNT;
      gain_p_r     <= RST_GAIN_P;
      gain_i_r     <= RST_GAIN_I;
      gain_d_r     <= RST_GAIN_D;
      duty_limit_r <= RST_DUTY_LIMIT;
      start_duty_r <= RST_START_DUTY;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_COUNT: target_r     <= cfg_data[TARGET_W-1:0];
        CFG_GAIN_P:       gain_p_r     <= cfg_data;
        CFG_GAIN_I:       gain_i_r     <= cfg_data;
        CFG_GAIN_D:       gain_d_r     <= cfg_data;
        CFG_DUTY_LIMIT:   duty_limit_r <= cfg_data;
        CFG_START_DUTY:   start_duty_r <= cfg_data;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register feeds the result register through the update logic
  // ---------------------------------------------------------------------------
  logic          s1_valid_r;
  func_t         s1_func_r;
  logic [NW-1:0] s1_pulse_r;
  logic          out_valid_r;
  logic          adv;
  logic          in_acc;

  // Advance the held item when the result register is free or is being taken.
  assign adv          = s1_valid_r && (!out_valid_r || out_item.ready);
  assign in_item.ready = !s1_valid_r || adv;
  assign in_acc       = in_item.valid && in_item.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload of the held item; no reset needed.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r  <= in_item.func;
      s1_pulse_r <= {in_item.right_pulse, in_item.left_pulse};
    end
  end

  // ---------------------------------------------------------------------------
  // Wheel state and PID update
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0]          count_r [NW];
  logic signed [ERR_W-1:0]     prev_r  [NW];
  logic signed [ACC_WIDTH-1:0] sum_r   [NW];
  logic [DUTY_W-1:0]           duty_r  [NW];

  logic [COUNT_W-1:0]          count_nxt [NW];
  logic signed [ERR_W-1:0]     prev_nxt  [NW];
  logic signed [ACC_WIDTH-1:0] sum_nxt   [NW];
  logic [DUTY_W-1:0]           duty_nxt  [NW];

  logic signed [ERR_W:0]       e_raw   [NW];
  logic signed [ERR_W-1:0]     e       [NW];
  logic signed [ERR_W:0]       d       [NW];
  logic signed [PP_W-1:0]      pp      [NW];
  logic signed [PD_W-1:0]      pd      [NW];
  logic signed [PI_W-1:0]      pi      [NW];
  logic signed [TW-1:0]        t       [NW];
  logic [TW-9:0]               q       [NW];
  logic [DUTY_W-1:0]           tick_duty [NW];
  logic signed [SW-1:0]        s_ext   [NW];
  logic signed [ACC_WIDTH-1:0] s_sat   [NW];

  always_comb begin
    for (int w = 0; w < NW; w++) begin
      // Error, saturated at the low end; the high end cannot exceed 255.
      e_raw[w] = $signed({{(ERR_W+1-TARGET_W){1'b0}}, target_r})
               - $signed({1'b0, count_r[w]});
      if (e_raw[w][ERR_W] && !e_raw[w][ERR_W-1]) begin
        e[w] = {1'b1, {(ERR_W-1){1'b0}}};
      end else begin
        e[w] = e_raw[w][ERR_W-1:0];
      end
      d[w] = $signed({e[w][ERR_W-1], e[w]}) - $signed({prev_r[w][ERR_W-1], prev_r[w]});

      // Three parallel products in units of 1/256.
      pp[w] = $signed({1'b0, gain_p_r}) * e[w];
      pd[w] = $signed({1'b0, gain_d_r}) * d[w];
      pi[w] = $signed({1'b0, gain_i_r}) * sum_r[w];

      t[w] = TW'(pp[w]) + TW'(pd[w]) + TW'(pi[w])
           + TW'($signed({1'b0, duty_r[w], 8'd0}));
      q[w] = t[w][TW-1:8];

      // Negative drops to zero; otherwise floor and clamp to the limit.
      if (t[w][TW-1]) begin
        tick_duty[w] = '0;
      end else if (q[w] > (TW-8)'(duty_limit_r)) begin
        tick_duty[w] = duty_limit_r;
      end else begin
        tick_duty[w] = q[w][DUTY_W-1:0];
      end

      // Sum update, saturated to the signed ACC_WIDTH range.
      s_ext[w] = SW'(sum_r[w]) + SW'(e[w]);
      if (s_ext[w][SW-1:ACC_WIDTH-1] == '0 || s_ext[w][SW-1:ACC_WIDTH-1] == '1) begin
        s_sat[w] = s_ext[w][ACC_WIDTH-1:0];
      end else if (s_ext[w][SW-1]) begin
        s_sat[w] = {1'b1, {(ACC_WIDTH-1){1'b0}}};
      end else begin
        s_sat[w] = {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end

      // Hold by default.
      count_nxt[w] = count_r[w];
      prev_nxt[w]  = prev_r[w];
      sum_nxt[w]   = sum_r[w];
      duty_nxt[w]  = duty_r[w];
      case (s1_func_r)
        FUNC_PULSE: begin
          if (s1_pulse_r[w] && count_r[w] != '1) begin
            count_nxt[w] = count_r[w] + COUNT_W'(1);
          end
        end
        FUNC_TICK: begin
          count_nxt[w] = '0;
          prev_nxt[w]  = e[w];
          sum_nxt[w]   = s_sat[w];
          duty_nxt[w]  = tick_duty[w];
        end
        FUNC_CLEAR: begin
          count_nxt[w] = '0;
          prev_nxt[w]  = '0;
          sum_nxt[w]   = '0;
          duty_nxt[w]  = start_duty_r;  // loaded unclamped
        end
        default: ;  // unused code reports the current state
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < NW; w++) begin
        count_r[w] <= '0;
        prev_r[w]  <= '0;
        sum_r[w]   <= '0;
        duty_r[w]  <= RST_START_DUTY;
      end
    end else if (adv) begin
      for (int w = 0; w < NW; w++) begin
        count_r[w] <= count_nxt[w];
        prev_r[w]  <= prev_nxt[w];
        sum_r[w]   <= sum_nxt[w];
        duty_r[w]  <= duty_nxt[w];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: state after the update of the advancing item
  // ---------------------------------------------------------------------------
  logic [DUTY_W-1:0]       out_duty_r [NW];
  logic signed [ERR_W-1:0] out_err_r  [NW];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int w = 0; w < NW; w++) begin
        out_duty_r[w] <= duty_nxt[w];
        out_err_r[w]  <= prev_nxt[w];
      end
    end
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.left_duty   = out_duty_r[0];
  assign out_item.right_duty  = out_duty_r[1];
  assign out_item.left_error  = out_err_r[0];
  assign out_item.right_error = out_err_r[1];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_tick_clears_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_func_r == FUNC_TICK) |=> (count_r[0] == '0 && count_r[1] == '0))
    else $error("pulse counts not cleared by a tick");

  a_tick_duty_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_func_r == FUNC_TICK) |=>
      (out_item.left_duty <= $past(duty_limit_r) && out_item.right_duty <= $past(duty_limit_r)))
    else $error("tick result duty above limit");

  a_clear_loads_start: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_func_r == FUNC_CLEAR) |=>
      (out_item.left_duty == $past(start_duty_r) && out_item.right_duty == $past(start_duty_r)
       && out_item.left_error == '0 && out_item.right_error == '0))
    else $error("clear did not load start duty");

  a_empty_takes_item: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_item.ready)
    else $error("input stalled with empty input register");

endmodule

`default_nettype wire

[test/dual_wheel_pid_duty_control_unit_tb.sv]
// Self-checking bench for the dual-wheel PID duty controller: directed table, then random periods.
`timescale 1ns / 1ps

module dual_wheel_pid_duty_control_unit_tb;
  import pdc_pkg::*;

  // Spare function code: the block must leave its state alone and report it.
  localparam func_t FUNC_SPARE = 2'd3;

  localparam int SUM_W        = ACC_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1150;
  // Pulses in the long burst: drive the error far below zero before a tick.
  localparam int BURST_PULSES = 200;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One result item as seen on the output channel.
  typedef struct {
    logic [DUTY_W-1:0]       left_duty;
    logic [DUTY_W-1:0]       right_duty;
    logic signed [ERR_W-1:0] left_error;
    logic signed [ERR_W-1:0] right_error;
  } duty_report_t;

  // Loop state of one wheel.
  typedef struct {
    logic [COUNT_W-1:0]      count;
    logic signed [ERR_W-1:0] prev_err;
    logic signed [SUM_W-1:0] err_sum;
    logic [DUTY_W-1:0]       duty;
  } wheel_state_t;

  // One row of the directed table: an item, or a register write.
  typedef struct {
    row_kind_t    kind;
    func_t        func;
    bit           lp;
    bit           rp;
    cfg_index_t   idx;
    cfg_data_t    val;
    bit           has_exp;
    duty_report_t want;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  cfg_index_t cfg_index;
  cfg_data_t  cfg_data;

  pdc_in_if  in_ch();
  pdc_out_if out_ch();

  dual_wheel_pid_duty_control_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Mirror of the configuration registers, updated with each write.
  logic [TARGET_W-1:0] target_now;
  logic [GAIN_W-1:0]   kp_now;
  logic [GAIN_W-1:0]   ki_now;
  logic [GAIN_W-1:0]   kd_now;
  logic [DUTY_W-1:0]   limit_now;
  logic [DUTY_W-1:0]   start_now;

  wheel_state_t left_wheel;
  wheel_state_t right_wheel;

  duty_report_t duty_expected_q[$];
  stim_row_t    stim_rows[$];
  duty_report_t no_exp;

  int unsigned error_count;
  int unsigned result_count;
  int unsigned rand_sent;
  int unsigned cycle_count;
  int          sink_hold;
  bit          quiet;

  // Clock: 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic wheel_state_t cleared_wheel(logic [DUTY_W-1:0] duty);
    wheel_state_t w;
    w.count    = '0;
    w.prev_err = '0;
    w.err_sum  = '0;
    w.duty     = duty;
    return w;
  endfunction

  // Count one encoder edge, holding at the counter ceiling.
  function automatic wheel_state_t pulsed_wheel(wheel_state_t w);
    if (w.count != {COUNT_W{1'b1}})
      w.count = w.count + 1'b1;
    return w;
  endfunction

  // Close the loop on one wheel: PID term in 1/256 units added to the held duty.
  function automatic wheel_state_t ticked_wheel(wheel_state_t w);
    longint err, der, acc, tot, quo, sum, hi, lo;
    hi  = (longint'(1) <<< (SUM_W - 1)) - 1;
    lo  = -hi - 1;
    err = longint'(target_now) - longint'(w.count);
    if (err < -32768)
      err = -32768;
    if (err > 32767)
      err = 32767;
    der = err - longint'(w.prev_err);
    acc = longint'(kp_now) * err + longint'(kd_now) * der
        + longint'(ki_now) * longint'(w.err_sum);
    tot = longint'(w.duty) * 256 + acc;
    // Negative totals floor at zero; otherwise drop the fraction and clamp.
    if (tot < 0) begin
      w.duty = '0;
    end else begin
      quo = tot >>> 8;
      if (quo > longint'(limit_now))
        w.duty = limit_now;
      else
        w.duty = quo[DUTY_W-1:0];
    end
    w.count    = '0;
    w.prev_err = err[ERR_W-1:0];
    sum = longint'(w.err_sum) + err;
    if (sum > hi)
      sum = hi;
    if (sum < lo)
      sum = lo;
    w.err_sum = sum[SUM_W-1:0];
    return w;
  endfunction

  // Advance both wheels by one item and return the state it reports.
  function automatic duty_report_t advance_duties(func_t f, bit lp, bit rp);
    duty_report_t r;
    case (f)
      FUNC_PULSE: begin
        if (lp)
          left_wheel = pulsed_wheel(left_wheel);
        if (rp)
          right_wheel = pulsed_wheel(right_wheel);
      end
      FUNC_TICK: begin
        left_wheel  = ticked_wheel(left_wheel);
        right_wheel = ticked_wheel(right_wheel);
      end
      FUNC_CLEAR: begin
        left_wheel  = cleared_wheel(start_now);
        right_wheel = cleared_wheel(start_now);
      end
      default: begin
      end
    endcase
    r.left_duty   = left_wheel.duty;
    r.right_duty  = right_wheel.duty;
    r.left_error  = left_wheel.prev_err;
    r.right_error = right_wheel.prev_err;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle pattern: mostly none, some short gaps, a few long ones.
  // ---------------------------------------------------------------------------

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return 0;
    else if (r < 95)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Register values: extremes often, otherwise anywhere in range.
  function automatic cfg_data_t pick_value(int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15)
      return '0;
    else if (r < 30)
      return cfg_data_t'(hi);
    return cfg_data_t'($urandom_range(0, hi));
  endfunction

  // Gains: keep most of them moderate so the duty moves instead of pinning.
  function automatic cfg_data_t pick_gain();
    if ($urandom_range(0, 99) < 55)
      return cfg_data_t'($urandom_range(0, 1023));
    return pick_value(65535);
  endfunction

  function automatic bit coin();
    return bit'($urandom_range(0, 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    $display("MISMATCH at result %0d: %s", result_count, what);
    error_count++;
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want)
      report_mismatch($sformatf("%s expected %h got %h", name, want, got));
  endtask

  // Take each result item and compare it with the oldest expectation.
  always @(posedge clk) begin : result_monitor
    duty_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (duty_expected_q.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        want = duty_expected_q.pop_front();
        check_field("left_duty", want.left_duty, out_ch.left_duty);
        check_field("right_duty", want.right_duty, out_ch.right_duty);
        check_field("left_error", want.left_error, out_ch.left_error);
        check_field("right_error", want.right_error, out_ch.right_error);
      end
      result_count++;
    end
  end

  // Result side: stall at random, unless a quiet stretch is running.
  always @(posedge clk) begin
    if (quiet) begin
      out_ch.ready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold    <= sink_hold - 1;
      out_ch.ready <= 1'b0;
    end else begin
      sink_hold    <= pick_gap();
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one item, hold it until taken, then record what it should report.
  // Call at a rising edge; returns at the edge that accepted the item.
  task automatic send_item(func_t f, bit lp, bit rp, bit has_exp, duty_report_t want);
    int           gap;
    duty_report_t pred;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= f;
    in_ch.left_pulse  <= lp;
    in_ch.right_pulse <= rp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // The predictor always advances; a typed-in row overrides its answer.
    pred = advance_duties(f, lp, rp);
    duty_expected_q.push_back(has_exp ? want : pred);
  endtask

  // Random item: counts toward the random total unless the block ignores it.
  task automatic drive(func_t f, bit lp, bit rp);
    send_item(f, lp, rp, 1'b0, no_exp);
    if (f != FUNC_SPARE)
      rand_sent++;
  endtask

  // Write one register once every result has drained, so the block is idle.
  task automatic write_reg(cfg_index_t idx, cfg_data_t val);
    in_ch.valid <= 1'b0;
    while (duty_expected_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_TARGET_COUNT: target_now = val[TARGET_W-1:0];
      CFG_GAIN_P:       kp_now     = val;
      CFG_GAIN_I:       ki_now     = val;
      CFG_GAIN_D:       kd_now     = val;
      CFG_DUTY_LIMIT:   limit_now  = val;
      CFG_START_DUTY:   start_now  = val;
      default: begin
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------------

  task automatic add_item(func_t f, bit lp, bit rp);
    stim_row_t row;
    row.kind    = ROW_ITEM;
    row.func    = f;
    row.lp      = lp;
    row.rp      = rp;
    row.idx     = CFG_TARGET_COUNT;
    row.val     = '0;
    row.has_exp = 1'b0;
    row.want    = no_exp;
    stim_rows.push_back(row);
  endtask

  task automatic add_checked(func_t f, bit lp, bit rp, int ld, int rd, int le, int re);
    stim_row_t row;
    row.kind             = ROW_ITEM;
    row.func             = f;
    row.lp               = lp;
    row.rp               = rp;
    row.idx              = CFG_TARGET_COUNT;
    row.val              = '0;
    row.has_exp          = 1'b1;
    row.want.left_duty   = ld[DUTY_W-1:0];
    row.want.right_duty  = rd[DUTY_W-1:0];
    row.want.left_error  = le[ERR_W-1:0];
    row.want.right_error = re[ERR_W-1:0];
    stim_rows.push_back(row);
  endtask

  task automatic add_cfg(cfg_index_t idx, cfg_data_t val);
    stim_row_t row;
    row.kind    = ROW_CFG;
    row.func    = FUNC_PULSE;
    row.lp      = 1'b0;
    row.rp      = 1'b0;
    row.idx     = idx;
    row.val     = val;
    row.has_exp = 1'b0;
    row.want    = no_exp;
    stim_rows.push_back(row);
  endtask

  // Watchdog: end a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    int unsigned mode;
    int unsigned stop_at;
    int unsigned n;
    int unsigned n_hi;

    // Drive every input to a known value from time zero.
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_TARGET_COUNT;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_PULSE;
    in_ch.left_pulse  = 1'b0;
    in_ch.right_pulse = 1'b0;
    out_ch.ready      = 1'b0;
    sink_hold         = 0;
    quiet             = 1'b0;
    error_count       = 0;
    result_count      = 0;
    rand_sent         = 0;
    no_exp.left_duty   = '0;
    no_exp.right_duty  = '0;
    no_exp.left_error  = '0;
    no_exp.right_error = '0;

    // Predictor starts from the reset state of the block.
    target_now  = RST_TARGET_COUNT;
    kp_now      = RST_GAIN_P;
    ki_now      = RST_GAIN_I;
    kd_now      = RST_GAIN_D;
    limit_now   = RST_DUTY_LIMIT;
    start_now   = RST_START_DUTY;
    left_wheel  = cleared_wheel(RST_START_DUTY);
    right_wheel = cleared_wheel(RST_START_DUTY);

    // Directed table. Typed-in results hold for the reset state, clears,
    // clamps at the extremes and the zero floor; the rest go to the predictor.
    // Spare code with pulse bits set: nothing moves, reset state reported.
    add_checked(FUNC_SPARE, 1'b1, 1'b1, 9000, 9000, 0, 0);
    add_item(FUNC_PULSE, 1'b1, 1'b0);
    add_item(FUNC_PULSE, 1'b0, 1'b1);
    add_item(FUNC_PULSE, 1'b1, 1'b1);
    add_item(FUNC_PULSE, 1'b0, 1'b0);
    // Pulse bits on a tick are ignored.
    add_item(FUNC_TICK, 1'b1, 1'b1);
    add_item(FUNC_TICK, 1'b0, 1'b0);
    add_item(FUNC_SPARE, 1'b0, 1'b0);
    add_checked(FUNC_CLEAR, 1'b1, 1'b1, 9000, 9000, 0, 0);
    // All registers but the start duty at their ceiling: the duty pins at the limit.
    add_cfg(CFG_TARGET_COUNT, 16'd255);
    add_cfg(CFG_GAIN_P, 16'hFFFF);
    add_cfg(CFG_GAIN_I, 16'hFFFF);
    add_cfg(CFG_GAIN_D, 16'hFFFF);
    add_cfg(CFG_DUTY_LIMIT, 16'hFFFF);
    add_checked(FUNC_TICK, 1'b0, 1'b0, 65535, 65535, 255, 255);
    add_checked(FUNC_TICK, 1'b0, 1'b0, 65535, 65535, 255, 255);
    // Zero start duty plus a negative error: the total goes negative, floor at 0.
    add_cfg(CFG_START_DUTY, 16'd0);
    add_cfg(CFG_TARGET_COUNT, 16'd0);
    add_checked(FUNC_CLEAR, 1'b0, 1'b0, 0, 0, 0, 0);
    add_item(FUNC_PULSE, 1'b1, 1'b1);
    add_checked(FUNC_TICK, 1'b0, 1'b0, 0, 0, -1, -1);
    // Start duty above the limit: a clear loads it raw, the next tick clamps.
    add_cfg(CFG_DUTY_LIMIT, 16'd100);
    add_cfg(CFG_START_DUTY, 16'hFFFF);
    add_checked(FUNC_CLEAR, 1'b0, 1'b0, 65535, 65535, 0, 0);
    add_checked(FUNC_TICK, 1'b0, 1'b0, 100, 100, 0, 0);
    // Zero limit.
    add_cfg(CFG_DUTY_LIMIT, 16'd0);
    add_checked(FUNC_TICK, 1'b0, 1'b0, 0, 0, 0, 0);
    // Zero gains leave the duty where the clear put it.
    add_cfg(CFG_GAIN_P, 16'd0);
    add_cfg(CFG_GAIN_I, 16'd0);
    add_cfg(CFG_GAIN_D, 16'd0);
    add_cfg(CFG_TARGET_COUNT, 16'd20);
    add_cfg(CFG_DUTY_LIMIT, 16'd10000);
    add_cfg(CFG_START_DUTY, 16'd9000);
    add_checked(FUNC_CLEAR, 1'b0, 1'b0, 9000, 9000, 0, 0);
    add_checked(FUNC_TICK, 1'b0, 1'b0, 9000, 9000, 20, 20);

    // Synchronous reset, released once.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG)
        write_reg(stim_rows[i].idx, stim_rows[i].val);
      else
        send_item(stim_rows[i].func, stim_rows[i].lp, stim_rows[i].rp,
                  stim_rows[i].has_exp, stim_rows[i].want);
    end

    // Long pulse burst: a small negative sum first, then a long run of
    // pulses; the tick after that drives the error far below zero.
    write_reg(CFG_TARGET_COUNT, 16'd0);
    write_reg(CFG_GAIN_P, RST_GAIN_P);
    write_reg(CFG_GAIN_I, RST_GAIN_I);
    write_reg(CFG_GAIN_D, RST_GAIN_D);
    quiet = 1'b1;
    send_item(FUNC_CLEAR, 1'b0, 1'b0, 1'b0, no_exp);
    repeat (40) send_item(FUNC_PULSE, 1'b1, 1'b1, 1'b0, no_exp);
    send_item(FUNC_TICK, 1'b0, 1'b0, 1'b0, no_exp);
    repeat (BURST_PULSES) send_item(FUNC_PULSE, 1'b1, 1'b1, 1'b0, no_exp);
    send_item(FUNC_TICK, 1'b0, 1'b0, 1'b0, no_exp);
    send_item(FUNC_TICK, 1'b0, 1'b0, 1'b0, no_exp);
    quiet = 1'b0;

    // Random phases: fresh settings each phase, then in half the phases well-formed
    // control periods, otherwise sum-pushing tick runs or plain noise.
    while (rand_sent < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 3);
      write_reg(CFG_TARGET_COUNT, (mode == 2) ? cfg_data_t'(255) : pick_value(255));
      write_reg(CFG_GAIN_P, pick_gain());
      write_reg(CFG_GAIN_I, pick_gain());
      write_reg(CFG_GAIN_D, pick_gain());
      write_reg(CFG_DUTY_LIMIT, pick_value(65535));
      write_reg(CFG_START_DUTY, pick_value(65535));
      quiet   = ($urandom_range(0, 4) == 0);
      stop_at = rand_sent + $urandom_range(80, 200);
      if (coin())
        drive(FUNC_CLEAR, coin(), coin());
      while (rand_sent < stop_at) begin
        case (mode)
          0, 1: begin
            // One control period: optional clear, pulses near the target, tick.
            if ($urandom_range(0, 5) == 0)
              drive(FUNC_CLEAR, coin(), coin());
            n_hi = (2 * target_now > 110) ? 120 : 2 * target_now + 10;
            n    = $urandom_range(0, n_hi);
            repeat (n) begin
              if ($urandom_range(0, 19) == 0)
                drive(func_t'($urandom_range(0, 3)), coin(), coin());
              else
                drive(FUNC_PULSE, coin(), coin());
            end
            drive(FUNC_TICK, coin(), coin());
          end
          2: begin
            // Mostly ticks with a high target: pushes the sum to its ceiling.
            if ($urandom_range(0, 9) == 0)
              drive(FUNC_PULSE, coin(), coin());
            else
              drive(FUNC_TICK, coin(), coin());
          end
          default: begin
            drive(func_t'($urandom_range(0, 3)), coin(), coin());
          end
        endcase
      end
      quiet = 1'b0;
    end

    // Drain, then let the result channel settle before the summary.
    in_ch.valid <= 1'b0;
    while (duty_expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
